// ===== design/glcd_pkg.sv =====
// Shared types, constants, microprogram and color conversion for the glyph row renderer.
package glcd_pkg;

  localparam int MAX_GLYPH_WIDTH  = 32;
  localparam int MAX_GLYPH_HEIGHT = 64;

  localparam int CNT_W   = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam int PC_W    = 4;
  localparam int PROD_W  = 14;
  localparam int SHIFT_W = 8;
  localparam int RECIP_W = 13;
  localparam int RECIP_SH = 19;
  localparam int PROD2_W = PROD_W + RECIP_W;

  // floor(p / 100) == (p * 5243) >> 19 for every p below 2**14
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);

  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_RASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;

  localparam logic [2:0] REG_FG    = 3'd0;
  localparam logic [2:0] REG_BG    = 3'd1;
  localparam logic [2:0] REG_GH    = 3'd2;
  localparam logic [2:0] REG_PCT   = 3'd3;
  localparam logic [2:0] REG_SCR_W = 3'd4;
  localparam logic [2:0] REG_SCR_H = 3'd5;

  localparam logic [PC_W-1:0] STEP_IDLE  = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_MUL1  = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_MUL2  = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_SETUP = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_CASET = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_X0    = PC_W'(5);
  localparam logic [PC_W-1:0] STEP_X1    = PC_W'(6);
  localparam logic [PC_W-1:0] STEP_RASET = PC_W'(7);
  localparam logic [PC_W-1:0] STEP_Y0    = PC_W'(8);
  localparam logic [PC_W-1:0] STEP_Y1    = PC_W'(9);
  localparam logic [PC_W-1:0] STEP_RAMWR = PC_W'(10);
  localparam logic [PC_W-1:0] STEP_PIX   = PC_W'(11);

  typedef enum logic [2:0] {OP_NOP, OP_LOAD, OP_MUL1, OP_MUL2, OP_SETUP} op_t;

  typedef enum logic [3:0] {
    EM_NONE, EM_CASET, EM_X0, EM_X1, EM_RASET, EM_Y0, EM_Y1, EM_RAMWR, EM_PIX
  } emit_t;

  typedef enum logic [2:0] {J_NEXT, J_WAIT, J_SKIP, J_NOWIN, J_LOOP, J_GOTO} jmp_t;

  typedef struct packed {
    op_t             op;
    emit_t           emit;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    op_t   op;
    logic  op_en;
    emit_t emit;
    logic  emit_en;
    logic  in_rdy;
  } seq_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic skip;
    logic no_win;
    logic cnt_zero;
    logic cnt_last;
  } dp_stat_t;

  typedef struct packed {
    logic [15:0] fg565;
    logic [15:0] bg565;
    logic [6:0]  gh;
    logic [6:0]  pct;
    logic [11:0] scr_w;
    logic [11:0] scr_h;
  } glcd_cfg_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uw;
    unique case (pc)
      STEP_IDLE:  uw = '{OP_LOAD,  EM_NONE,  J_WAIT,  STEP_IDLE};
      STEP_MUL1:  uw = '{OP_MUL1,  EM_NONE,  J_SKIP,  STEP_IDLE};
      STEP_MUL2:  uw = '{OP_MUL2,  EM_NONE,  J_NEXT,  STEP_IDLE};
      STEP_SETUP: uw = '{OP_SETUP, EM_NONE,  J_NOWIN, STEP_PIX};
      STEP_CASET: uw = '{OP_NOP,   EM_CASET, J_NEXT,  STEP_IDLE};
      STEP_X0:    uw = '{OP_NOP,   EM_X0,    J_NEXT,  STEP_IDLE};
      STEP_X1:    uw = '{OP_NOP,   EM_X1,    J_NEXT,  STEP_IDLE};
      STEP_RASET: uw = '{OP_NOP,   EM_RASET, J_NEXT,  STEP_IDLE};
      STEP_Y0:    uw = '{OP_NOP,   EM_Y0,    J_NEXT,  STEP_IDLE};
      STEP_Y1:    uw = '{OP_NOP,   EM_Y1,    J_NEXT,  STEP_IDLE};
      STEP_RAMWR: uw = '{OP_NOP,   EM_RAMWR, J_NEXT,  STEP_IDLE};
      STEP_PIX:   uw = '{OP_NOP,   EM_PIX,   J_LOOP,  STEP_IDLE};
      default:    uw = '{OP_NOP,   EM_NONE,  J_GOTO,  STEP_IDLE};
    endcase
    return uw;
  endfunction

  function automatic logic [15:0] to565(input logic [23:0] rgb);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = (rgb[23:16] & 8'hF8) + {5'b0, rgb[15:13]};
    lo = 8'({(rgb[15:8] & 8'h1C), 3'b000}) + {3'b0, rgb[7:3]};
    return {hi, lo};
  endfunction

endpackage

// ===== design/glcd_if.sv =====
// Channel interfaces: glyph row input, bus word output, configuration writes.
interface glcd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] origin_x;
  logic [15:0] origin_y;
  logic [5:0]  row_index;
  logic [5:0]  glyph_width;
  logic [31:0] row_bits;
  modport source (output valid, origin_x, origin_y, row_index, glyph_width, row_bits,
                  input ready);
  modport sink (input valid, origin_x, origin_y, row_index, glyph_width, row_bits,
                output ready);
endinterface

interface glcd_out_if;
  logic        valid;
  logic        ready;
  logic        is_data;
  logic [15:0] bus_word;
  logic        is_wide;
  logic        last;
  modport source (output valid, is_data, bus_word, is_wide, last, input ready);
  modport sink (input valid, is_data, bus_word, is_wide, last, output ready);
endinterface

interface glcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/glcd_sequencer.sv =====
// Microprogram sequencer: step counter, control store lookup and jump logic.
module glcd_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  glcd_pkg::dp_stat_t   stat,
  output glcd_pkg::seq_ctrl_t  ctrl
);

  logic [glcd_pkg::PC_W-1:0] pc_r, pc_nxt;
  glcd_pkg::ucode_t          uw;
  logic                      go;
  logic                      pix_idle;

  assign uw       = glcd_pkg::ucode_rom(pc_r);
  assign pix_idle = (uw.emit == glcd_pkg::EM_PIX) && stat.cnt_zero;

  always_comb begin
    if (uw.jmp == glcd_pkg::J_WAIT) begin
      go = stat.in_valid;
    end else if (uw.emit == glcd_pkg::EM_NONE || pix_idle) begin
      go = 1'b1;
    end else begin
      go = stat.out_free;
    end
  end

  always_comb begin
    pc_nxt = pc_r;
    if (go) begin
      case (uw.jmp)
        glcd_pkg::J_NEXT:  pc_nxt = pc_r + 1'b1;
        glcd_pkg::J_WAIT:  pc_nxt = pc_r + 1'b1;
        glcd_pkg::J_SKIP:  pc_nxt = stat.skip ? uw.target : pc_r + 1'b1;
        glcd_pkg::J_NOWIN: pc_nxt = stat.no_win ? uw.target : pc_r + 1'b1;
        // stay on the pixel step until the final pixel leaves
        glcd_pkg::J_LOOP:  pc_nxt = (stat.cnt_zero || stat.cnt_last) ? uw.target : pc_r;
        default:           pc_nxt = uw.target;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= glcd_pkg::STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.op      = uw.op;
  assign ctrl.op_en   = go;
  assign ctrl.emit    = uw.emit;
  assign ctrl.emit_en = go && (uw.emit != glcd_pkg::EM_NONE) && !pix_idle;
  assign ctrl.in_rdy  = (uw.jmp == glcd_pkg::J_WAIT);

endmodule

// ===== design/glcd_datapath.sv =====
// Datapath: row registers, shear multiply, window and clip setup, bus word output register.
module glcd_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  glcd_pkg::seq_ctrl_t  ctrl,
  input  glcd_pkg::glcd_cfg_t  cfg,
  output glcd_pkg::dp_stat_t   stat,
  glcd_in_if.sink              in_ch,
  glcd_out_if.source           out_ch
);

  localparam int CW = glcd_pkg::CNT_W;

  logic [15:0] x_r, y_r;
  logic [5:0]  row_r;
  logic [CW-1:0] w_r;
  logic [31:0] bits_r;
  logic [glcd_pkg::PROD_W-1:0]  prod_r;
  logic [glcd_pkg::SHIFT_W-1:0] shift_r;
  logic [15:0] x0_r, x1_r, y0_r, y1_r;
  logic [CW-1:0] cnt_r;

  logic        out_valid_r, out_is_data_r, out_is_wide_r, out_last_r;
  logic [15:0] out_word_r;

  logic        in_fire, obl;
  logic [CW-1:0] w_in;
  logic [6:0]  rows_left;
  logic [glcd_pkg::PROD2_W-1:0] prod2;
  logic [15:0] xs, yr;
  logic [16:0] ysum;
  logic        draw, x_in;
  logic [15:0] room;
  logic [CW-1:0] cnt_up, cnt_set;
  logic [15:0] word_sel;

  assign in_fire     = in_ch.valid && ctrl.in_rdy;
  assign in_ch.ready = ctrl.in_rdy;
  assign obl         = (cfg.pct != 7'd0);

  assign w_in = (in_ch.glyph_width > 6'(glcd_pkg::MAX_GLYPH_WIDTH))
              ? CW'(glcd_pkg::MAX_GLYPH_WIDTH) : CW'(in_ch.glyph_width);

  assign rows_left = cfg.gh - {1'b0, row_r};
  assign prod2     = glcd_pkg::PROD2_W'(prod_r) * glcd_pkg::PROD2_W'(glcd_pkg::RECIP_100);

  // upright mode has a zero percent, so the shift is zero there as well
  assign xs   = x_r + 16'(shift_r);
  assign yr   = y_r + 16'(row_r);
  assign ysum = {1'b0, y_r} + 17'(row_r);
  assign draw = ysum < 17'(cfg.scr_h);
  assign x_in = x_r < 16'(cfg.scr_w);
  assign room = 16'(cfg.scr_w) - x_r;

  always_comb begin
    if (!x_in) begin
      cnt_up = '0;
    end else if (room < 16'(w_r)) begin
      cnt_up = CW'(room);
    end else begin
      cnt_up = w_r;
    end
    if (obl) begin
      cnt_set = w_r;
    end else begin
      cnt_set = draw ? cnt_up : '0;
    end
  end

  always_comb begin
    case (ctrl.emit)
      glcd_pkg::EM_CASET: word_sel = {8'h00, glcd_pkg::CMD_CASET};
      glcd_pkg::EM_RASET: word_sel = {8'h00, glcd_pkg::CMD_RASET};
      glcd_pkg::EM_RAMWR: word_sel = {8'h00, glcd_pkg::CMD_RAMWR};
      glcd_pkg::EM_X0:    word_sel = x0_r;
      glcd_pkg::EM_X1:    word_sel = x1_r;
      glcd_pkg::EM_Y0:    word_sel = y0_r;
      glcd_pkg::EM_Y1:    word_sel = y1_r;
      glcd_pkg::EM_PIX:   word_sel = bits_r[31] ? cfg.fg565 : cfg.bg565;
      default:            word_sel = 16'h0000;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.op_en) begin
      case (ctrl.op)
        glcd_pkg::OP_LOAD: begin
          x_r    <= in_ch.origin_x;
          y_r    <= in_ch.origin_y;
          row_r  <= in_ch.row_index;
          w_r    <= w_in;
          bits_r <= in_ch.row_bits;
        end
        glcd_pkg::OP_MUL1: begin
          prod_r <= glcd_pkg::PROD_W'(rows_left) * glcd_pkg::PROD_W'(cfg.pct);
        end
        glcd_pkg::OP_MUL2: begin
          shift_r <= prod2[glcd_pkg::RECIP_SH +: glcd_pkg::SHIFT_W];
        end
        glcd_pkg::OP_SETUP: begin
          x0_r  <= xs;
          x1_r  <= xs + 16'(w_r) - 16'd1;
          y0_r  <= obl ? yr : y_r;
          y1_r  <= obl ? yr : (y_r + 16'(cfg.gh) - 16'd1);
          cnt_r <= cnt_set;
        end
        default: begin
        end
      endcase
    end
    if (ctrl.emit_en && ctrl.emit == glcd_pkg::EM_PIX) begin
      bits_r <= {bits_r[30:0], 1'b0};
      cnt_r  <= cnt_r - 1'b1;
    end
    if (ctrl.emit_en) begin
      out_word_r    <= word_sel;
      out_is_data_r <= !(ctrl.emit == glcd_pkg::EM_CASET || ctrl.emit == glcd_pkg::EM_RASET
                         || ctrl.emit == glcd_pkg::EM_RAMWR);
      out_is_wide_r <= !(ctrl.emit == glcd_pkg::EM_CASET || ctrl.emit == glcd_pkg::EM_RASET
                         || ctrl.emit == glcd_pkg::EM_RAMWR);
      out_last_r    <= (ctrl.emit == glcd_pkg::EM_RAMWR && cnt_r == '0)
                    || (ctrl.emit == glcd_pkg::EM_PIX && cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.is_data  = out_is_data_r;
  assign out_ch.bus_word = out_word_r;
  assign out_ch.is_wide  = out_is_wide_r;
  assign out_ch.last     = out_last_r;

  assign stat.in_valid = in_fire;
  assign stat.out_free = !out_valid_r || out_ch.ready;
  assign stat.skip     = {1'b0, row_r} >= cfg.gh;
  assign stat.no_win   = !(obl || row_r == 6'd0);
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.cnt_last = (cnt_r == CW'(1));

endmodule

// ===== design/glyph_row_to_lcd_pixel_stream.sv =====
// Top level: configuration registers, microprogram sequencer and datapath.
//
//  channel  | dir | handshake     | payload
//  in_ch    | in  | valid / ready | origin_x, origin_y, row_index, glyph_width, row_bits
//  out_ch   | out | valid / ready | is_data, bus_word, is_wide, last
//  cfg_ch   | in  | valid / ready | index (0..5), data
//
// One glyph row per run of the microprogram: 1 accept step, 3 setup steps (shear
// multiply, reciprocal multiply, window and clip), then one bus word per step:
// 7 window words when a window is sent plus one word per pixel, and one idle pixel
// step when no pixel goes out. A row outside the glyph returns to idle from the first
// multiply step. The single output register sets the pace: a stalled out_ch holds
// the step counter.
// Reset (rst_n low, synchronous) returns the step counter to idle and the
// configuration registers to their defaults; cfg_ch is always ready.
module glyph_row_to_lcd_pixel_stream (
  input  logic        clk,
  input  logic        rst_n,
  glcd_in_if.sink     in_ch,
  glcd_out_if.source  out_ch,
  glcd_cfg_if.sink    cfg_ch
);

  logic [23:0] fg_r, bg_r;
  logic [6:0]  gh_r, pct_r;
  logic [11:0] scr_w_r, scr_h_r;

  glcd_pkg::glcd_cfg_t cfg;
  glcd_pkg::seq_ctrl_t ctrl;
  glcd_pkg::dp_stat_t  stat;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r    <= 24'hFFFFFF;
      bg_r    <= 24'h000000;
      gh_r    <= 7'd16;
      pct_r   <= 7'd0;
      scr_w_r <= 12'd160;
      scr_h_r <= 12'd128;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        glcd_pkg::REG_FG:    fg_r    <= cfg_ch.data;
        glcd_pkg::REG_BG:    bg_r    <= cfg_ch.data;
        glcd_pkg::REG_GH:    gh_r    <= cfg_ch.data[6:0];
        glcd_pkg::REG_PCT:   pct_r   <= cfg_ch.data[6:0];
        glcd_pkg::REG_SCR_W: scr_w_r <= cfg_ch.data[11:0];
        glcd_pkg::REG_SCR_H: scr_h_r <= cfg_ch.data[11:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.fg565 = glcd_pkg::to565(fg_r);
  assign cfg.bg565 = glcd_pkg::to565(bg_r);
  assign cfg.gh    = gh_r;
  assign cfg.pct   = pct_r;
  assign cfg.scr_w = scr_w_r;
  assign cfg.scr_h = scr_h_r;

  glcd_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  glcd_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .cfg    (cfg),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ===== design/glcd_checker.sv =====
// Port-level checker for the glyph row renderer and its bind to the top level.
module glcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_is_data,
  input logic [15:0] out_bus_word,
  input logic        out_is_wide,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("bus word dropped while stalled");

  a_one_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second row taken before the first is processed");

  a_cmd_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_data |-> !out_is_wide && out_bus_word[15:8] == 8'h00)
    else $error("command word not a single byte");

  a_data_wide: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_data |-> out_is_wide)
    else $error("data word not marked two bytes");

  a_busy_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a row");

endmodule

bind glyph_row_to_lcd_pixel_stream glcd_checker u_glcd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_is_data  (out_ch.is_data),
  .out_bus_word (out_ch.bus_word),
  .out_is_wide  (out_ch.is_wide),
  .out_last     (out_ch.last)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the glyph row renderer: directed and random rows.
module tb_top;

  localparam int DRAIN_CYCLES    = 64;
  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 60;

  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [5:0]  row_index;
    logic [5:0]  glyph_width;
    logic [31:0] row_bits;
  } glyph_row_t;

  typedef struct packed {
    logic        is_data;
    logic [15:0] word;
    logic        is_wide;
    logic        last;
  } bus_word_t;

  typedef struct {
    logic [23:0] fg_rgb;
    logic [23:0] bg_rgb;
    logic [6:0]  height;
    logic [6:0]  shear_pct;
    logic [11:0] scr_w;
    logic [11:0] scr_h;
  } panel_regs_t;

  logic clk = 1'b0;
  logic rst_n;

  glcd_in_if  in_ch ();
  glcd_out_if out_ch ();
  glcd_cfg_if cfg_ch ();

  glyph_row_to_lcd_pixel_stream dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  panel_regs_t panel;
  bus_word_t   pending_words[$];
  int          errors        = 0;
  int          in_idle_pct   = 0;
  int          out_stall_pct = 0;
  int          hold_off_left = 0;
  int          quiet_cycles  = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [15:0] pack_565(input logic [23:0] rgb);
    int unsigned r;
    int unsigned g;
    int unsigned b;
    logic [7:0]  hi;
    logic [7:0]  lo;
    r  = rgb[23:16];
    g  = rgb[15:8];
    b  = rgb[7:0];
    hi = 8'((r & 32'hF8) + (g >> 5));
    lo = 8'(((g & 32'h1C) << 3) + (b >> 3));
    return {hi, lo};
  endfunction

  function automatic void push_word(input logic is_data, input logic [15:0] word,
                                    input logic is_wide);
    bus_word_t w;
    w.is_data = is_data;
    w.word    = word;
    w.is_wide = is_wide;
    w.last    = 1'b0;
    pending_words.push_back(w);
  endfunction

  function automatic void push_window(input logic [15:0] x0, input logic [15:0] x1,
                                      input logic [15:0] y0, input logic [15:0] y1);
    push_word(1'b0, {8'h00, glcd_pkg::CMD_CASET}, 1'b0);
    push_word(1'b1, x0, 1'b1);
    push_word(1'b1, x1, 1'b1);
    push_word(1'b0, {8'h00, glcd_pkg::CMD_RASET}, 1'b0);
    push_word(1'b1, y0, 1'b1);
    push_word(1'b1, y1, 1'b1);
    push_word(1'b0, {8'h00, glcd_pkg::CMD_RAMWR}, 1'b0);
  endfunction

  // Append the bus words that one accepted row should produce.
  function automatic void render_row(input glyph_row_t r);
    int unsigned wid;
    int unsigned shift;
    int          n_start;
    logic [15:0] xs;
    logic [15:0] yr;
    logic [15:0] fg;
    logic [15:0] bg;
    bit          draw;
    n_start = pending_words.size();
    wid     = (r.glyph_width > glcd_pkg::MAX_GLYPH_WIDTH)
            ? glcd_pkg::MAX_GLYPH_WIDTH : r.glyph_width;
    fg      = pack_565(panel.fg_rgb);
    bg      = pack_565(panel.bg_rgb);
    draw    = 1'b1;
    if (r.row_index >= panel.height) return;
    if (panel.shear_pct == 0) begin
      if (r.row_index == 0)
        push_window(r.origin_x, 16'(int'(r.origin_x) + wid - 1),
                    r.origin_y, 16'(int'(r.origin_y) + panel.height - 1));
      if (int'(r.origin_y) + int'(r.row_index) >= int'(panel.scr_h)) draw = 1'b0;
    end else begin
      shift = ((int'(panel.height) - int'(r.row_index)) * int'(panel.shear_pct)) / 100;
      xs    = 16'(int'(r.origin_x) + shift);
      yr    = 16'(int'(r.origin_y) + int'(r.row_index));
      push_window(xs, 16'(int'(xs) + wid - 1), yr, yr);
    end
    if (draw) begin
      for (int unsigned j = 0; j < wid; j++) begin
        if (panel.shear_pct == 0 && int'(r.origin_x) + j >= int'(panel.scr_w)) break;
        push_word(1'b1, r.row_bits[31 - j] ? fg : bg, 1'b1);
      end
    end
    if (pending_words.size() > n_start) pending_words[pending_words.size() - 1].last = 1'b1;
  endfunction

  function automatic glyph_row_t make_row(input logic [15:0] x, input logic [15:0] y,
                                          input logic [5:0] row, input logic [5:0] w,
                                          input logic [31:0] bits);
    glyph_row_t r;
    r.origin_x    = x;
    r.origin_y    = y;
    r.row_index   = row;
    r.glyph_width = w;
    r.row_bits    = bits;
    return r;
  endfunction

  // Called right after a falling edge; returns right after one.
  task automatic send_row(input glyph_row_t r);
    while ($urandom_range(99) < in_idle_pct) @(negedge clk);
    in_ch.origin_x    = r.origin_x;
    in_ch.origin_y    = r.origin_y;
    in_ch.row_index   = r.row_index;
    in_ch.glyph_width = r.glyph_width;
    in_ch.row_bits    = r.row_bits;
    in_ch.valid       = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    render_row(r);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      glcd_pkg::REG_FG:    panel.fg_rgb    = value;
      glcd_pkg::REG_BG:    panel.bg_rgb    = value;
      glcd_pkg::REG_GH:    panel.height    = value[6:0];
      glcd_pkg::REG_PCT:   panel.shear_pct = value[6:0];
      glcd_pkg::REG_SCR_W: panel.scr_w     = value[11:0];
      glcd_pkg::REG_SCR_H: panel.scr_h     = value[11:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Wait for every expected word, then let a row that emits nothing finish too.
  task automatic quiesce();
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic int pick_extreme(input int lo, input int hi, input int mid_lo,
                                      input int mid_hi);
    case ($urandom_range(3))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(mid_lo, mid_hi);
    endcase
  endfunction

  task automatic program_random_panel(input bit oblique);
    write_reg(glcd_pkg::REG_FG, 24'($urandom));
    write_reg(glcd_pkg::REG_BG, 24'($urandom));
    write_reg(glcd_pkg::REG_GH, 24'(pick_extreme(1, 64, 1, 64)));
    write_reg(glcd_pkg::REG_PCT, oblique ? 24'(pick_extreme(1, 100, 1, 100)) : 24'd0);
    write_reg(glcd_pkg::REG_SCR_W, 24'(pick_extreme(1, 4095, 16, 320)));
    write_reg(glcd_pkg::REG_SCR_H, 24'(pick_extreme(1, 4095, 16, 320)));
  endtask

  task automatic test_reset_defaults();
    send_row(make_row(16'd0, 16'd0, 6'd0, 6'd8, 32'hA500_0000));
    send_row(make_row(16'd156, 16'd127, 6'd0, 6'd8, 32'hF0F0_0000));
    send_row(make_row(16'd156, 16'd127, 6'd1, 6'd8, 32'hFFFF_FFFF));
    send_row(make_row(16'd10, 16'd20, 6'd15, 6'd16, 32'h8001_0000));
    send_row(make_row(16'd10, 16'd20, 6'd16, 6'd16, 32'hFFFF_FFFF));
    send_row(make_row(16'd10, 16'd20, 6'd63, 6'd16, 32'hFFFF_FFFF));
  endtask

  task automatic test_color_conversion();
    quiesce();
    write_reg(glcd_pkg::REG_FG, 24'h000000);
    write_reg(glcd_pkg::REG_BG, 24'hFFFFFF);
    send_row(make_row(16'd0, 16'd0, 6'd0, 6'd32, 32'h0F0F_3C3C));
    quiesce();
    write_reg(glcd_pkg::REG_FG, 24'h123456);
    write_reg(glcd_pkg::REG_BG, 24'hEDCBA9);
    send_row(make_row(16'd0, 16'd0, 6'd0, 6'd32, 32'h5555_AAAA));
  endtask

  task automatic test_upright_clipping();
    quiesce();
    write_reg(glcd_pkg::REG_GH, 24'd1);
    write_reg(glcd_pkg::REG_SCR_W, 24'd1);
    write_reg(glcd_pkg::REG_SCR_H, 24'd1);
    send_row(make_row(16'd0, 16'd0, 6'd0, 6'd32, 32'hFFFF_FFFF));
    send_row(make_row(16'hFFFF, 16'hFFFF, 6'd0, 6'd63, 32'hFFFF_FFFF));
    send_row(make_row(16'd0, 16'd0, 6'd0, 6'd0, 32'hFFFF_FFFF));
    quiesce();
    write_reg(glcd_pkg::REG_GH, 24'd64);
    write_reg(glcd_pkg::REG_SCR_W, 24'd4095);
    write_reg(glcd_pkg::REG_SCR_H, 24'd4095);
    send_row(make_row(16'd4063, 16'd4032, 6'd63, 6'd32, 32'hFFFF_FFFF));
    send_row(make_row(16'd4063, 16'd4032, 6'd62, 6'd32, 32'hC3C3_C3C3));
    send_row(make_row(16'd4064, 16'd4032, 6'd62, 6'd32, 32'h3C3C_3C3C));
    send_row(make_row(16'd0, 16'd0, 6'd0, 6'd33, 32'hFFFF_FFFF));
    send_row(make_row(16'd0, 16'd0, 6'd5, 6'd0, 32'hFFFF_FFFF));
  endtask

  task automatic test_oblique_shear();
    quiesce();
    write_reg(glcd_pkg::REG_PCT, 24'd100);
    send_row(make_row(16'hFFC0, 16'd0, 6'd0, 6'd16, 32'hDEAD_BEEF));
    send_row(make_row(16'd0, 16'd100, 6'd63, 6'd32, 32'h1234_5678));
    send_row(make_row(16'd50, 16'd50, 6'd10, 6'd0, 32'hFFFF_FFFF));
    send_row(make_row(16'd50, 16'd50, 6'd20, 6'd63, $urandom()));
    quiesce();
    write_reg(glcd_pkg::REG_PCT, 24'd1);
    send_row(make_row(16'd7, 16'd9, 6'd0, 6'd12, 32'hFFF0_0000));
    quiesce();
    write_reg(glcd_pkg::REG_GH, 24'd1);
    write_reg(glcd_pkg::REG_PCT, 24'd100);
    send_row(make_row(16'd7, 16'd9, 6'd0, 6'd5, 32'hA800_0000));
    send_row(make_row(16'd7, 16'd9, 6'd1, 6'd5, 32'hA800_0000));
    quiesce();
    write_reg(glcd_pkg::REG_GH, 24'd33);
    write_reg(glcd_pkg::REG_PCT, 24'd37);
    send_row(make_row(16'd100, 16'd200, 6'd5, 6'd24, 32'h0123_4567));
    send_row(make_row(16'hFFFF, 16'hFFFF, 6'd1, 6'd8, 32'h8100_0000));
  endtask

  task automatic test_random_phase(input int n_items, input int in_idle, input int out_stall,
                                   input bit oblique);
    int         sent;
    int         rows;
    glyph_row_t r;
    quiesce();
    program_random_panel(oblique);
    in_idle_pct   = in_idle;
    out_stall_pct = out_stall;
    sent          = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 75) begin
        // whole glyph top to bottom; now and then cut short
        if ($urandom_range(4) == 0) begin
          r.origin_x = 16'($urandom);
          r.origin_y = 16'($urandom);
        end else begin
          r.origin_x = 16'($urandom_range(0, int'(panel.scr_w) + 4));
          r.origin_y = 16'($urandom_range(0, int'(panel.scr_h) + 4));
        end
        r.glyph_width = 6'($urandom_range(1, glcd_pkg::MAX_GLYPH_WIDTH));
        rows = ($urandom_range(9) == 0) ? $urandom_range(1, panel.height) : panel.height;
        for (int row = 0; row < rows && sent < n_items; row++) begin
          r.row_index = 6'(row);
          r.row_bits  = $urandom();
          send_row(r);
          sent++;
        end
      end else begin
        send_row(make_row(16'($urandom), 16'($urandom), 6'($urandom), 6'($urandom),
                          $urandom()));
        sent++;
      end
    end
  endtask

  // Stall the bus side for a long stretch while rows keep coming.
  task automatic test_output_backpressure();
    glyph_row_t r;
    quiesce();
    program_random_panel(1'b1);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_off_left = HOLD_OFF_CYCLES;
    for (int i = 0; i < 24; i++) begin
      r = make_row(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                   6'($urandom_range(0, int'(panel.height) - 1)),
                   6'($urandom_range(1, glcd_pkg::MAX_GLYPH_WIDTH)), $urandom());
      send_row(r);
    end
  endtask

  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ch.ready  = 1'b0;
      hold_off_left = hold_off_left - 1;
    end else begin
      out_ch.ready = ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    bus_word_t want;
    bus_word_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.is_data, out_ch.bus_word, out_ch.is_wide, out_ch.last};
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: is_data=%0b word=%h is_wide=%0b last=%0b",
                 $time, got.is_data, got.word, got.is_wide, got.last);
      end else begin
        want = pending_words.pop_front();
        if (got.is_data !== want.is_data || got.word !== want.word ||
            got.is_wide !== want.is_wide || got.last !== want.last) begin
          errors++;
          $display("%0t: mismatch: expected is_data=%0b word=%h is_wide=%0b last=%0b, got is_data=%0b word=%h is_wide=%0b last=%0b",
                   $time, want.is_data, want.word, want.is_wide, want.last,
                   got.is_data, got.word, got.is_wide, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("glyph_row_to_lcd_pixel_stream regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.origin_x    = '0;
    in_ch.origin_y    = '0;
    in_ch.row_index   = '0;
    in_ch.glyph_width = '0;
    in_ch.row_bits    = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    panel = '{24'hFFFFFF, 24'h000000, 7'd16, 7'd0, 12'd160, 12'd128};
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_color_conversion();
    test_upright_clipping();
    test_oblique_shear();
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0:       test_random_phase(PHASE_ITEMS, 0, 0, p >= 4);
        1:       test_random_phase(PHASE_ITEMS, 65, 0, p >= 4);
        2:       test_random_phase(PHASE_ITEMS, 0, 65, p >= 4);
        default: test_random_phase(PHASE_ITEMS, 22, 22, p >= 4);
      endcase
    end
    test_output_backpressure();
    quiesce();

    if (errors == 0)
      $display("glyph_row_to_lcd_pixel_stream regression: pass");
    else
      $display("glyph_row_to_lcd_pixel_stream regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
design/glcd_pkg.sv
design/glcd_if.sv
design/glcd_sequencer.sv
design/glcd_datapath.sv
design/glyph_row_to_lcd_pixel_stream.sv
design/glcd_checker.sv
dv/tb_top.sv
